FILE: hdl/lcfr_pkg.sv
// Package for the length/checksum frame receiver.
// Holds the receive phase type, byte kind codes, the header reset value and the minimum length.
// No dependencies.
`default_nettype none

package lcfr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_RECV = 2'd2
  } rx_phase_t;

  typedef enum logic [2:0] {
    KIND_IGNORED = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_LENGTH  = 3'd2,
    KIND_BODY    = 3'd3,
    KIND_CHECK   = 3'd4
  } byte_kind_t;

  localparam logic [7:0] HEADER_RESET = 8'hAA;
  localparam logic [7:0] MIN_LENGTH   = 8'd2;

endpackage

`default_nettype wire

FILE: hdl/length_checksum_frame_receiver.sv
// An accepted byte goes through the input register, then the output register.
// Throughput: one byte per cycle unless in_stall; an input and an output register part
// the two channels, so a new byte is taken while a finished word waits to be taken.
// Reset (rst, synchronous, active high) empties both registers, sets header_byte to 0xAA
// and leaves the receiver waiting for a length byte with count, length and sum cleared.
// Frame receiver top level: parses header/length/body/checksum bytes.
// Depends on lcfr_pkg.
`default_nettype none

module length_checksum_frame_receiver
  import lcfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // byte input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      byte_out,
  output logic [7:0]      frame_position,
  output logic [2:0]      byte_kind,
  output logic            frame_done,
  output logic            frame_good,
  output logic            length_error,
  // header byte register write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic       [7:0] header_byte;
  logic             in_reg_valid;
  logic       [7:0] in_reg_byte;
  logic             advance;
  logic             in_take;

  rx_phase_t        rx_phase, rx_phase_next;
  logic       [7:0] byte_count, byte_count_next;
  logic       [7:0] frame_length, frame_length_next;
  logic       [7:0] running_sum, running_sum_next;

  logic       [7:0] pos_next;
  byte_kind_t       kind_next;
  logic             done_next;
  logic             good_next;
  logic             lerr_next;
  logic             is_hdr;
  logic       [7:0] count_inc;
  logic       [7:0] sum_b;

  // Handshakes: output register drains or is empty, input register moves forward
  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_reg_valid && !advance;
  assign in_take   = in_valid && !in_stall;

  // Header byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_byte <= cfg_data;
    end
  end

  // Input register: hold word until it moves to the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg_byte <= rx_byte;
    end
  end

  // Receive state registers, updated when a word enters the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase     <= PH_LEN;
      byte_count   <= '0;
      frame_length <= '0;
      running_sum  <= '0;
    end else if (in_reg_valid && advance) begin
      rx_phase     <= rx_phase_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
    end
  end

  // Next state and result fields for the word in the input register
  always_comb begin
    is_hdr            = (in_reg_byte == header_byte);
    count_inc         = byte_count + 8'd1;
    sum_b             = running_sum + in_reg_byte;
    rx_phase_next     = rx_phase;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    pos_next          = '0;
    kind_next         = KIND_IGNORED;
    done_next         = 1'b0;
    good_next         = 1'b0;
    lerr_next         = 1'b0;

    unique case (rx_phase)
      PH_LEN: begin
        pos_next  = 8'd1;
        kind_next = KIND_LENGTH;
        if (in_reg_byte < MIN_LENGTH) begin
          // reject short length and go idle
          done_next         = 1'b1;
          lerr_next         = 1'b1;
          rx_phase_next     = PH_IDLE;
          byte_count_next   = '0;
          frame_length_next = '0;
          running_sum_next  = '0;
        end else begin
          frame_length_next = in_reg_byte;
          byte_count_next   = 8'd1;
          running_sum_next  = in_reg_byte;
          rx_phase_next     = PH_RECV;
        end
      end
      PH_RECV: begin
        pos_next        = count_inc;
        byte_count_next = count_inc;
        if (count_inc == frame_length) begin
          // checksum byte closes the frame
          kind_next         = KIND_CHECK;
          done_next         = 1'b1;
          good_next         = (sum_b == 8'd0);
          rx_phase_next     = PH_IDLE;
          byte_count_next   = '0;
          frame_length_next = '0;
          running_sum_next  = '0;
        end else begin
          kind_next        = KIND_BODY;
          running_sum_next = sum_b;
        end
      end
      default: begin
        rx_phase_next = PH_IDLE;
        kind_next     = is_hdr ? KIND_HEADER : KIND_IGNORED;
      end
    endcase

    // A header byte aborts an open frame and restarts reception
    if (is_hdr) begin
      if (rx_phase_next == PH_RECV) begin
        done_next = 1'b1;
        good_next = 1'b0;
      end
      rx_phase_next     = PH_LEN;
      byte_count_next   = '0;
      frame_length_next = '0;
      running_sum_next  = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg_valid) begin
      byte_out       <= in_reg_byte;
      frame_position <= pos_next;
      byte_kind      <= kind_next;
      frame_done     <= done_next;
      frame_good     <= good_next;
      length_error   <= lerr_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lcfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
// Depends on lcfr_pkg and length_checksum_frame_receiver.
`default_nettype none

module lcfr_checker
  import lcfr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] byte_out,
  input wire logic [7:0] frame_position,
  input wire logic [2:0] byte_kind,
  input wire logic       frame_done,
  input wire logic       frame_good,
  input wire logic       length_error
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_out) && $stable(byte_kind))
    else $error("result word changed while stalled");

  // input stalls only behind a stalled result word
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // rejected length is a closing length byte at position one
  a_len_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_error |->
      frame_done && byte_kind == KIND_LENGTH && frame_position == 8'd1)
    else $error("length error on wrong word");

  // good flag only on a checksum byte that closes a frame
  a_good: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_good |-> frame_done && byte_kind == KIND_CHECK && !length_error)
    else $error("good flag on non-checksum word");

  // header and ignored bytes sit outside any frame
  a_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_kind == KIND_IGNORED || byte_kind == KIND_HEADER) |->
      frame_position == 8'd0 && !frame_done && !frame_good)
    else $error("position or done on header/ignored word");

endmodule

bind length_checksum_frame_receiver lcfr_checker u_lcfr_checker (.*);

`default_nettype wire

FILE: tb/length_checksum_frame_receiver_test.sv
// Testbench for length_checksum_frame_receiver: sends received bytes, predicts every
// result word with a local frame parser and checks each word field by field.
// Depends on lcfr_pkg and the receiver RTL.
module length_checksum_frame_receiver_test;
  import lcfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TARGET_BYTES   = 560;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] pos;
    byte_kind_t kind;
    logic       done;
    logic       good;
    logic       lerr;
  } rx_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] byte_out;
  logic [7:0] frame_position;
  logic [2:0] byte_kind;
  logic       frame_done;
  logic       frame_good;
  logic       length_error;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  // Parser state of the predictor
  rx_phase_t  parse_phase  = PH_LEN;
  logic [7:0] parse_count  = 8'h00;
  logic [7:0] parse_length = 8'h00;
  logic [7:0] parse_sum    = 8'h00;
  logic [7:0] hdr_value    = HEADER_RESET;

  rx_word_t pending_words[$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  words_checked = 0;
  int  good_frames = 0;
  int  failed_frames = 0;
  int  length_errors = 0;
  int  cfg_writes = 0;
  bit  gaps_on = 1'b1;
  logic stall_on = 1'b1;
  int  hold_gen = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  always #2 clk = ~clk;

  length_checksum_frame_receiver DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .byte_out       (byte_out),
    .frame_position (frame_position),
    .byte_kind      (byte_kind),
    .frame_done     (frame_done),
    .frame_good     (frame_good),
    .length_error   (length_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void clear_frame();
    parse_count  = 8'h00;
    parse_length = 8'h00;
    parse_sum    = 8'h00;
  endfunction

  // Advance the parser by one byte and return the word it should produce
  function automatic rx_word_t parse_byte(input logic [7:0] b);
    rx_word_t   w;
    logic [7:0] total;
    logic       is_hdr;
    w = '{data: b, pos: 8'h00, kind: KIND_IGNORED, done: 1'b0, good: 1'b0, lerr: 1'b0};
    is_hdr = (b == hdr_value);
    case (parse_phase)
      PH_LEN: begin
        w.pos  = 8'd1;
        w.kind = KIND_LENGTH;
        if (b < MIN_LENGTH) begin
          w.done = 1'b1;
          w.lerr = 1'b1;
          parse_phase = PH_IDLE;
          clear_frame();
        end else begin
          parse_length = b;
          parse_count  = 8'd1;
          parse_sum    = b;
          parse_phase  = PH_RECV;
        end
      end
      PH_RECV: begin
        parse_count = parse_count + 8'd1;
        w.pos = parse_count;
        if (parse_count == parse_length) begin
          total  = parse_sum + b;
          w.kind = KIND_CHECK;
          w.done = 1'b1;
          w.good = (total == 8'h00);
          parse_phase = PH_IDLE;
          clear_frame();
        end else begin
          w.kind = KIND_BODY;
          parse_sum = parse_sum + b;
        end
      end
      default: begin
        parse_phase = PH_IDLE;
        w.kind = is_hdr ? KIND_HEADER : KIND_IGNORED;
      end
    endcase
    // A header byte aborts an open frame and restarts reception
    if (is_hdr) begin
      if (parse_phase == PH_RECV) begin
        w.done = 1'b1;
        w.good = 1'b0;
      end
      parse_phase = PH_LEN;
      clear_frame();
    end
    return w;
  endfunction

  // Offer one byte, hold it until taken, then record its expected word
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    pending_words.push_back(parse_byte(b));
    bytes_sent++;
  endtask

  // Random byte that differs from the header value
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    while (b == hdr_value) b = $urandom_range(0, 255);
    return b;
  endfunction

  // Header, length, body and checksum; optionally corrupt the checksum
  task automatic send_frame(input int len, input bit good_sum, input bit clean_body);
    logic [7:0] sum;
    logic [7:0] b;
    send_byte(hdr_value);
    send_byte(len[7:0]);
    sum = len[7:0];
    for (int i = 2; i < len; i++) begin
      b = clean_body ? body_byte() : 8'($urandom_range(0, 255));
      send_byte(b);
      sum = sum + b;
    end
    b = 8'h00 - sum;
    if (!good_sum) b = b ^ 8'($urandom_range(1, 255));
    send_byte(b);
  endtask

  // Stop sending and wait until every expected word has come out
  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    drain_words();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hdr_value = v;
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare every taken result word with the oldest expectation
  always @(posedge clk) begin : check_words
    rx_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual byte %0h kind %0d",
                 $time, byte_out, byte_kind);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        check_field("byte_out", want.data, byte_out);
        check_field("frame_position", want.pos, frame_position);
        check_field("byte_kind", 8'(want.kind), 8'(byte_kind));
        check_field("frame_done", 8'(want.done), 8'(frame_done));
        check_field("frame_good", 8'(want.good), 8'(frame_good));
        check_field("length_error", 8'(want.lerr), 8'(length_error));
        if (want.kind == KIND_CHECK && want.good) good_frames++;
        else if (want.done && !want.lerr) failed_frames++;
        if (want.lerr) length_errors++;
      end
    end
  end

  // Receiver side: long hold on request, otherwise random short stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (stall_on) stall_left = pick_gap();
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no transfer for %0d cycles", $time, quiet_cycles);
        $display("length_checksum_frame_receiver_test: FAIL");
        $finish;
      end
    end
  end

  // Right after reset the first byte is taken as a length
  task automatic test_first_length_after_reset();
    send_byte(8'h03);
    send_byte(8'h10);
    send_byte(8'hED);
    send_byte(8'h00);
  endtask

  // Shortest frame, bad checksum, short lengths, idle bytes, header inside a frame
  task automatic test_frame_cases();
    send_byte(8'hAA); send_byte(8'h02); send_byte(8'hFE);
    send_byte(8'hAA); send_byte(8'h04); send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'h77);
    send_byte(8'hAA); send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA); send_byte(8'h01);
    // header in the body, then a header in the length slot restarts reception
    send_byte(8'hAA); send_byte(8'h05); send_byte(8'h11); send_byte(8'hAA);
    send_byte(8'hAA);
    // header in the checksum slot completes the frame
    send_byte(8'h03); send_byte(8'h53); send_byte(8'hAA);
    send_byte(8'h02); send_byte(8'hFE);
  endtask

  // Extreme and random header values, header used as a rejected length
  task automatic test_header_values();
    write_header(8'h00);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h02); send_byte(8'hFE);
    send_byte(8'h00); send_byte(8'h02); send_byte(8'hFE);
    write_header(8'h01);
    send_byte(8'h01); send_byte(8'h01); send_byte(8'h02); send_byte(8'hFE);
    write_header(8'hFF);
    send_byte(8'hFF); send_byte(8'h03); send_byte(8'h7F); send_byte(8'h7E);
    send_byte(8'h55); send_byte(8'hFF); send_byte(8'hFF);
    write_header(8'($urandom_range(0, 255)));
    send_frame(5, 1'b1, 1'b1);
    write_header(HEADER_RESET);
  endtask

  // Hold the output off while the sender keeps offering bytes
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    stall_on <= 1'b0;
    hold_gen <= hold_gen + 1;
    repeat (3) send_frame(6, 1'b1, 1'b1);
    gaps_on = 1'b1;
    stall_on <= 1'b1;
  endtask

  task automatic test_longest_frame();
    send_frame(255, 1'b1, 1'b1);
  endtask

  // Mostly well-formed frames, plus short lengths, noise and cut-off frames
  task automatic test_random_traffic();
    int r;
    int len;
    logic [7:0] v;
    while (bytes_sent < TARGET_BYTES) begin
      if ($urandom_range(0, 99) < 5) begin
        case ($urandom_range(0, 4))
          0: v = 8'h00;
          1: v = 8'hFF;
          2: v = 8'($urandom_range(0, 255));
          default: v = HEADER_RESET;
        endcase
        write_header(v);
      end
      if ($urandom_range(0, 99) < 8) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        stall_on <= ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(2, 10);
      else if (r < 98) len = $urandom_range(11, 40);
      else len = $urandom_range(41, 120);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(len, $urandom_range(0, 99) < 85, $urandom_range(0, 9) != 0);
      end else if (r < 80) begin
        send_byte(hdr_value);
        send_byte(8'($urandom_range(0, 1)));
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(hdr_value);
        send_byte(8'($urandom_range(4, 40)));
        repeat ($urandom_range(0, 2)) send_byte(body_byte());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_first_length_after_reset();
    test_frame_cases();
    test_header_values();
    test_output_backpressure();
    test_longest_frame();
    test_random_traffic();
    drain_words();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes over %0d header settings; checked %0d result words.",
             bytes_sent, cfg_writes + 1, words_checked);
    $display("Frames good %0d, bad or aborted %0d, short lengths %0d.",
             good_frames, failed_frames, length_errors);
    if (errors == 0) begin
      $display("length_checksum_frame_receiver_test: PASS");
    end else begin
      $display("length_checksum_frame_receiver_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lcfr_pkg.sv
hdl/length_checksum_frame_receiver.sv
hdl/lcfr_checker.sv
tb/length_checksum_frame_receiver_test.sv
